[src/sla_pkg.sv]
// ----------------------------------------------------------------------------
// sla_pkg
// Shared types, codes and the AZERTY lookup for the scancode line assembler.
// ----------------------------------------------------------------------------
package sla_pkg;

    localparam int DEFAULT_BUFFER_SIZE = 16;

    localparam logic [4:0] EVENT_KEY   = 5'd1;
    localparam logic [1:0] VALUE_PRESS = 2'd1;
    localparam logic [9:0] KEY_END     = 10'h060;
    localparam logic [9:0] KEY_SHIFT   = 10'h02A;
    localparam logic [6:0] UNMAPPED_CHAR = 7'h2D;

    localparam logic [1:0] STATUS_CHAR  = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef enum logic [1:0] {
        KIND_CHAR  = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_FULL  = 2'd2
    } out_kind_t;

    typedef struct packed {
        logic      set_shift;
        logic      append;
        logic      start_drain;
        logic      advance;
        logic      clear_count;
        logic      load_out;
        out_kind_t kind;
    } sla_cmd_t;

    typedef struct packed {
        logic key_press;
        logic key_end;
        logic key_shift;
        logic key_zero;
        logic count_zero;
        logic count_limit;
        logic out_free;
        logic drain_last;
    } sla_stat_t;

    function automatic logic [6:0] map_plain(input logic [5:0] code);
        logic [6:0] c;
        begin
            c = 7'd0;
            unique case (code)
                6'h02: c = 7'h26;
                6'h04: c = 7'h22;
                6'h06: c = 7'h28;
                6'h07: c = 7'h2D;
                6'h09: c = 7'h5F;
                6'h0C: c = 7'h29;
                6'h10: c = 7'h61;
                6'h11: c = 7'h7A;
                6'h12: c = 7'h65;
                6'h13: c = 7'h72;
                6'h14: c = 7'h74;
                6'h15: c = 7'h79;
                6'h16: c = 7'h75;
                6'h17: c = 7'h69;
                6'h18: c = 7'h6F;
                6'h19: c = 7'h70;
                6'h1E: c = 7'h71;
                6'h1F: c = 7'h73;
                6'h20: c = 7'h64;
                6'h21: c = 7'h66;
                6'h22: c = 7'h67;
                6'h23: c = 7'h68;
                6'h24: c = 7'h6A;
                6'h25: c = 7'h6B;
                6'h26: c = 7'h6C;
                6'h27: c = 7'h6D;
                6'h2C: c = 7'h77;
                6'h2D: c = 7'h78;
                6'h2E: c = 7'h63;
                6'h2F: c = 7'h76;
                6'h30: c = 7'h62;
                6'h31: c = 7'h6E;
                6'h32: c = 7'h2C;
                6'h39: c = 7'h20;
                default: c = 7'd0;
            endcase
            return c;
        end
    endfunction

    function automatic logic [6:0] map_shifted(input logic [5:0] code);
        logic [6:0] c;
        begin
            c = 7'd0;
            unique case (code)
                6'h02: c = 7'h31;
                6'h03: c = 7'h32;
                6'h04: c = 7'h33;
                6'h05: c = 7'h34;
                6'h06: c = 7'h35;
                6'h07: c = 7'h36;
                6'h08: c = 7'h37;
                6'h09: c = 7'h38;
                6'h0A: c = 7'h39;
                6'h0B: c = 7'h30;
                6'h10: c = 7'h41;
                6'h11: c = 7'h5A;
                6'h12: c = 7'h45;
                6'h13: c = 7'h52;
                6'h14: c = 7'h54;
                6'h15: c = 7'h59;
                6'h16: c = 7'h55;
                6'h17: c = 7'h49;
                6'h18: c = 7'h4F;
                6'h19: c = 7'h50;
                6'h1E: c = 7'h51;
                6'h1F: c = 7'h53;
                6'h20: c = 7'h44;
                6'h21: c = 7'h46;
                6'h22: c = 7'h47;
                6'h23: c = 7'h48;
                6'h24: c = 7'h4A;
                6'h25: c = 7'h4B;
                6'h26: c = 7'h4C;
                6'h27: c = 7'h4D;
                6'h2C: c = 7'h57;
                6'h2D: c = 7'h58;
                6'h2E: c = 7'h43;
                6'h2F: c = 7'h56;
                6'h30: c = 7'h42;
                6'h31: c = 7'h4E;
                6'h32: c = 7'h3F;
                default: c = 7'd0;
            endcase
            return c;
        end
    endfunction

endpackage

[src/scancode_line_assembler.sv]
// Result path: an empty line end or a full buffer goes through the put state
// to the output register; a line drain reads each character from the
// registered store, then loads it into the output register.
// Throughput: one key word per cycle while no result is due; input is held in
// the put state and for the whole drain, longer while the result side stalls.
// Reset: rst_n clears the state, shift flag, count, drain pointer and out valid.
// ----------------------------------------------------------------------------
// scancode_line_assembler
// Builds text lines from barcode reader key words through an AZERTY table.
// ----------------------------------------------------------------------------
module scancode_line_assembler #(
    parameter int BUFFER_SIZE = sla_pkg::DEFAULT_BUFFER_SIZE
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [4:0] event_type,
    input  logic [9:0] key_code,
    input  logic [1:0] key_value,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [6:0] char_code,
    output logic [1:0] status,
    output logic       last
);
    import sla_pkg::*;

    sla_cmd_t  cmd;
    sla_stat_t stat;

    sla_control u_control (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sla_datapath #(
        .BUFFER_SIZE (BUFFER_SIZE)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .event_type (event_type),
        .key_code   (key_code),
        .key_value  (key_value),
        .cmd        (cmd),
        .stat       (stat),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .char_code  (char_code),
        .status     (status),
        .last       (last)
    );

endmodule

[src/sla_datapath.sv]
// ----------------------------------------------------------------------------
// sla_datapath
// Key decode, shift flag, line store, drain pointer and output register.
// ----------------------------------------------------------------------------
module sla_datapath #(
    parameter int BUFFER_SIZE = sla_pkg::DEFAULT_BUFFER_SIZE
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [4:0]         event_type,
    input  logic [9:0]         key_code,
    input  logic [1:0]         key_value,
    input  sla_pkg::sla_cmd_t  cmd,
    output sla_pkg::sla_stat_t stat,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [6:0]         char_code,
    output logic [1:0]         status,
    output logic               last
);
    import sla_pkg::*;

    localparam int DEPTH = BUFFER_SIZE - 1;
    localparam int CW    = $clog2(DEPTH);
    localparam logic [CW-1:0] LIMIT = CW'(BUFFER_SIZE - 2);

    logic [6:0]    mem [DEPTH];
    logic [6:0]    rd_data_reg;
    logic          shift_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] idx_reg;
    logic          out_valid_reg;
    logic [6:0]    char_reg;
    logic [1:0]    status_reg;
    logic          last_reg;
    logic [6:0]    mapped;
    logic [6:0]    new_char;
    logic          drain_last;

    always_comb
    begin
        mapped = 7'd0;
        if (key_code[9:6] == 4'd0)
        begin
            mapped = shift_reg ? map_shifted(key_code[5:0]) : map_plain(key_code[5:0]);
        end
        new_char = (mapped == 7'd0) ? UNMAPPED_CHAR : mapped;
    end

    assign drain_last = (CW'(idx_reg + CW'(1)) == count_reg);

    assign stat.key_press   = (event_type == EVENT_KEY) && (key_value == VALUE_PRESS);
    assign stat.key_end     = (key_code == KEY_END);
    assign stat.key_shift   = (key_code == KEY_SHIFT);
    assign stat.key_zero    = (key_code == 10'd0);
    assign stat.count_zero  = (count_reg == '0);
    assign stat.count_limit = (count_reg == LIMIT);
    assign stat.out_free    = !out_valid_reg || out_ready;
    assign stat.drain_last  = drain_last;

    // line store
    always_ff @(posedge clk)
    begin
        if (cmd.append)
        begin
            mem[count_reg] <= new_char;
        end
        rd_data_reg <= mem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= 1'b0;
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            if (cmd.set_shift)
            begin
                shift_reg <= 1'b1;
            end
            else if (cmd.append)
            begin
                shift_reg <= 1'b0;
            end

            if (cmd.clear_count)
            begin
                count_reg <= '0;
            end
            else if (cmd.append)
            begin
                count_reg <= (count_reg == LIMIT) ? '0 : CW'(count_reg + CW'(1));
            end

            if (cmd.start_drain)
            begin
                idx_reg <= '0;
            end
            else if (cmd.advance)
            begin
                idx_reg <= CW'(idx_reg + CW'(1));
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            unique case (cmd.kind)
                KIND_CHAR:
                begin
                    char_reg   <= rd_data_reg;
                    status_reg <= STATUS_CHAR;
                    last_reg   <= drain_last;
                end
                KIND_EMPTY:
                begin
                    char_reg   <= 7'd0;
                    status_reg <= STATUS_EMPTY;
                    last_reg   <= 1'b1;
                end
                KIND_FULL:
                begin
                    char_reg   <= 7'd0;
                    status_reg <= STATUS_FULL;
                    last_reg   <= 1'b1;
                end
                default:
                begin
                    char_reg   <= 7'd0;
                    status_reg <= STATUS_FULL;
                    last_reg   <= 1'b1;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign char_code = char_reg;
    assign status    = status_reg;
    assign last      = last_reg;

endmodule

[src/sla_control.sv]
// ----------------------------------------------------------------------------
// sla_control
// Sequencer: classifies each accepted word and steps the line drain.
// ----------------------------------------------------------------------------
module sla_control (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  sla_pkg::sla_stat_t stat,
    output sla_pkg::sla_cmd_t  cmd
);
    import sla_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PUT,
        S_READ,
        S_EMIT
    } state_t;

    state_t    state_reg;
    state_t    state_next;
    out_kind_t kind_reg;
    out_kind_t kind_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        cmd.set_shift   = 1'b0;
        cmd.append      = 1'b0;
        cmd.start_drain = 1'b0;
        cmd.advance     = 1'b0;
        cmd.clear_count = 1'b0;
        cmd.load_out    = 1'b0;
        cmd.kind        = KIND_CHAR;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && stat.key_press)
                begin
                    priority if (stat.key_end)
                    begin
                        if (stat.count_zero)
                        begin
                            kind_next  = KIND_EMPTY;
                            state_next = S_PUT;
                        end
                        else
                        begin
                            cmd.start_drain = 1'b1;
                            state_next      = S_READ;
                        end
                    end
                    else if (stat.key_zero)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (stat.key_shift)
                    begin
                        cmd.set_shift = 1'b1;
                    end
                    else
                    begin
                        cmd.append = 1'b1;
                        if (stat.count_limit)
                        begin
                            kind_next  = KIND_FULL;
                            state_next = S_PUT;
                        end
                    end
                end
            end
            S_PUT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.kind     = kind_reg;
                    state_next   = S_IDLE;
                end
            end
            S_READ:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.kind     = KIND_CHAR;
                    if (stat.drain_last)
                    begin
                        cmd.clear_count = 1'b1;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                        state_next  = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kind_reg  <= KIND_CHAR;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

endmodule

[src/sla_checker.sv]
// ----------------------------------------------------------------------------
// sla_checker
// Port-level checks on the result channel of the scancode line assembler.
// ----------------------------------------------------------------------------
module sla_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [6:0] char_code,
    input logic [1:0] status,
    input logic       last
);
    import sla_pkg::*;

    // hold a stalled word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(char_code)
            && $stable(status) && $stable(last))
        else $error("result word changed while stalled");

    a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STATUS_CHAR |-> last)
        else $error("empty or full result without last");

    a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STATUS_CHAR |-> char_code == 7'd0)
        else $error("empty or full result with a character");

    a_char_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_CHAR |-> char_code != 7'd0)
        else $error("character result carries zero");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == STATUS_CHAR || status == STATUS_EMPTY
            || status == STATUS_FULL)
        else $error("undefined status code");

endmodule

bind scancode_line_assembler sla_checker u_sla_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .char_code (char_code),
    .status    (status),
    .last      (last)
);
